/* rtl/sequential_list_engine_defines.svh */
// Assertion macros for the checker file.
`ifndef SEQUENTIAL_LIST_ENGINE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sle_pkg.sv */
`default_nettype none
package sle_pkg;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_LOCATE = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_RANGE    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	localparam int ChunkBits = 8;

	typedef struct packed {
		logic       ins;
		logic       del;
		logic [7:0] pos0;
	} cell_ctl_t;

endpackage
`default_nettype wire

/* rtl/sle_cell.sv */
`default_nettype none
module sle_cell #(
	parameter int IDX  = 0,
	parameter int CNTW = 8
) (
	input  wire logic               clk,
	input  wire sle_pkg::cell_ctl_t ctl,
	input  wire logic signed [31:0] value,
	input  wire logic signed [31:0] left,
	input  wire logic signed [31:0] right,
	input  wire logic [CNTW-1:0]    count,
	output logic signed [31:0]      data_q,
	output logic                    match
);
	import sle_pkg::*;

	localparam int CW = (CNTW > 8) ? CNTW : 8;

	logic [CW-1:0] idx_c;
	logic [CW-1:0] pos_c;
	logic          at_or_above;
	logic          live;

	assign idx_c       = CW'(IDX);
	assign pos_c       = CW'(ctl.pos0);
	assign at_or_above = idx_c >= pos_c;
	assign live        = CNTW'(IDX) < count;
	assign match       = live && (data_q == value);

	always_ff @(posedge clk) begin
		if (ctl.ins && at_or_above) begin
			data_q <= (idx_c == pos_c) ? value : left;
		end else if (ctl.del && at_or_above) begin
			data_q <= right;
		end
	end

endmodule
`default_nettype wire

/* rtl/sequential_list_engine.sv */
// Insert, delete and clear answer in the cycle after the request, one request per cycle
// unless busy. Locate registers the match vector when taken, then scans it eight cells
// per cycle; done follows the chunk with the first match, or the last chunk if none.
// busy is high while a locate scans its chunks; the receiver cannot stall.
// arst_n clears the entry count and the control state; entry contents are not reset.
`default_nettype none
module sequential_list_engine #(
	parameter int CAPACITY = 128
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [1:0]         kind,
	input  wire logic [7:0]         position,
	input  wire logic signed [31:0] value,
	output logic                    busy,
	output logic                    done,
	output logic [1:0]              status,
	output logic [7:0]              found_position,
	output logic [7:0]              entry_count
);
	import sle_pkg::*;

	localparam int CNTW = $clog2(CAPACITY + 1);
	localparam int CW   = ((CNTW > 8) ? CNTW : 8) + 1;
	localparam int NCH  = (CAPACITY + ChunkBits - 1) / ChunkBits;
	localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int EW   = $clog2(ChunkBits);
	localparam int FW   = CHW + EW + 1;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t               state_q;
	logic [CNTW-1:0]      count_q;
	logic                 done_q;
	logic [1:0]           status_q;
	logic [7:0]           found_q;
	logic [CAPACITY-1:0]  match_q;
	logic [CHW-1:0]       chunk_q;

	logic                 accept;
	logic [CW-1:0]        pos_ext;
	logic [CW-1:0]        cnt_ext;
	logic                 full;
	logic                 ins_ok;
	logic                 del_ok;
	cell_ctl_t            ctl;
	logic signed [31:0]   data   [CAPACITY];
	logic [CAPACITY-1:0]  match;
	logic [NCH*ChunkBits-1:0] match_pad;
	logic [ChunkBits-1:0] bits;
	logic [EW-1:0]        enc;
	logic [FW-1:0]        fpos;

	assign accept  = start && !busy;
	assign busy    = state_q == S_SCAN;
	assign pos_ext = CW'(position);
	assign cnt_ext = CW'(count_q);
	assign full    = count_q == CNTW'(CAPACITY);
	assign ins_ok  = !full && (position != 8'd0) && (pos_ext <= cnt_ext + CW'(1));
	assign del_ok  = (position != 8'd0) && (pos_ext <= cnt_ext);

	always_comb begin
		ctl.ins  = accept && (kind == KIND_INSERT) && ins_ok;
		ctl.del  = accept && (kind == KIND_DELETE) && del_ok;
		ctl.pos0 = position - 8'd1;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_d;
		logic signed [31:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = value;
		end else begin : g_mid_l
			assign left_d = data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = data[i];
		end else begin : g_mid_r
			assign right_d = data[i+1];
		end
		sle_cell #(
			.IDX  (i),
			.CNTW (CNTW)
		) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.value  (value),
			.left   (left_d),
			.right  (right_d),
			.count  (count_q),
			.data_q (data[i]),
			.match  (match[i])
		);
	end

	assign match_pad = (NCH*ChunkBits)'(match_q);

	always_comb begin
		bits = '0;
		for (int c = 0; c < NCH; c++) begin
			if (chunk_q == CHW'(c)) begin
				bits = match_pad[c*ChunkBits +: ChunkBits];
			end
		end
		enc = '0;
		for (int b = ChunkBits - 1; b >= 0; b--) begin
			if (bits[b]) begin
				enc = EW'(b);
			end
		end
		fpos = {1'b0, chunk_q, enc} + FW'(1);
	end

	always_ff @(posedge clk) begin
		if (accept && (kind == KIND_LOCATE)) begin
			match_q <= match;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			found_q  <= '0;
			chunk_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						found_q  <= '0;
						status_q <= ST_OK;
						unique case (kind)
							KIND_INSERT: begin
								done_q <= 1'b1;
								if (full) begin
									status_q <= ST_FULL;
								end else if (!ins_ok) begin
									status_q <= ST_RANGE;
								end else begin
									count_q <= count_q + CNTW'(1);
								end
							end
							KIND_DELETE: begin
								done_q <= 1'b1;
								if (!del_ok) begin
									status_q <= ST_RANGE;
								end else begin
									count_q <= count_q - CNTW'(1);
								end
							end
							KIND_LOCATE: begin
								chunk_q <= '0;
								state_q <= S_SCAN;
							end
							KIND_CLEAR: begin
								done_q  <= 1'b1;
								count_q <= '0;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (|bits) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						found_q  <= 8'(fpos);
						state_q  <= S_IDLE;
					end else if (chunk_q == CHW'(NCH - 1)) begin
						done_q   <= 1'b1;
						status_q <= ST_NOTFOUND;
						found_q  <= '0;
						state_q  <= S_IDLE;
					end else begin
						chunk_q <= chunk_q + CHW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign found_position = found_q;
	assign entry_count    = 8'(count_q);

endmodule
`default_nettype wire

/* rtl/sle_checker.sv */
`default_nettype none
`include "sequential_list_engine_defines.svh"
module sle_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic [1:0]  kind,
	input wire logic        done,
	input wire logic [1:0]  status,
	input wire logic [7:0]  found_position,
	input wire logic [7:0]  entry_count
);
	import sle_pkg::*;

	logic take;
	logic found;
	logic miss;

	assign take  = start && !busy;
	assign found = found_position != 8'd0;
	assign miss  = status == ST_NOTFOUND;

	`SLE_ASSERT_NOW(a_found_ok, done && found, status == ST_OK, "position without ok")
	`SLE_ASSERT_NOW(a_notfound_zero, done && miss, !found, "not found with position")
	`SLE_ASSERT_NEXT(a_fast_done, take && (kind != KIND_LOCATE), done, "missing result")
	`SLE_ASSERT_NOW(a_done_idle, done, !busy, "result while busy")
	`SLE_ASSERT_NEXT(a_clear_zero, take && (kind == KIND_CLEAR), entry_count == '0, "entries kept")

endmodule

bind sequential_list_engine sle_checker u_sle_checker (.*);
`default_nettype wire

/* tb/tb.sv */
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sle_pkg::*;

	localparam int LIST_DEPTH   = 128;
	localparam int CYCLE_LIMIT  = 250000;
	localparam int DRAIN_CYCLES = 24;
	localparam int SEGMENT_LEN  = 50;

	typedef struct {
		status_t  st;
		bit [7:0] found;
		bit [7:0] cnt;
	} list_reply_t;

	typedef enum int {
		MODE_GROW,
		MODE_SHRINK,
		MODE_MIXED
	} walk_mode_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic [1:0]         kind;
	logic [7:0]         position;
	logic signed [31:0] value;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic [7:0]         found_position;
	logic [7:0]         entry_count;

	bit [31:0]   shadow_mem [LIST_DEPTH];
	int          shadow_len;
	list_reply_t pending_replies [$];

	int error_count;
	int cycle_count;
	int request_count;
	int kind_count [4];
	int status_count [4];
	int deepest_list;
	int deepest_match;
	int idle_pct;

	sequential_list_engine #(
		.CAPACITY(LIST_DEPTH)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.kind          (kind),
		.position      (position),
		.value         (value),
		.busy          (busy),
		.done          (done),
		.status        (status),
		.found_position(found_position),
		.entry_count   (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic list_reply_t apply_list_request(kind_t k, bit [7:0] p, bit [31:0] v);
		list_reply_t r;
		int          i;
		r.st    = ST_OK;
		r.found = '0;
		case (k)
			KIND_INSERT: begin
				if (shadow_len >= LIST_DEPTH) begin
					r.st = ST_FULL;
				end else if (p < 1 || p > shadow_len + 1) begin
					r.st = ST_RANGE;
				end else begin
					for (i = shadow_len; i >= p; i--)
						shadow_mem[i] = shadow_mem[i - 1];
					shadow_mem[p - 1] = v;
					shadow_len++;
				end
			end
			KIND_DELETE: begin
				if (p < 1 || p > shadow_len) begin
					r.st = ST_RANGE;
				end else begin
					for (i = p - 1; i + 1 < shadow_len; i++)
						shadow_mem[i] = shadow_mem[i + 1];
					shadow_len--;
				end
			end
			KIND_LOCATE: begin
				r.st = ST_NOTFOUND;
				for (i = 0; i < shadow_len; i++) begin
					if (shadow_mem[i] == v) begin
						r.st    = ST_OK;
						r.found = 8'(i + 1);
						break;
					end
				end
			end
			default: begin
				for (i = 0; i < LIST_DEPTH; i++)
					shadow_mem[i] = '0;
				shadow_len = 0;
			end
		endcase
		r.cnt = 8'(shadow_len);
		return r;
	endfunction

	task automatic send_request(kind_t k, bit [7:0] p, bit [31:0] v);
		bit          was_busy;
		list_reply_t r;
		start    <= 1'b1;
		kind     <= k;
		position <= p;
		value    <= v;
		do begin
			@(negedge clk);
			was_busy = (busy !== 1'b0);
			@(posedge clk);
		end while (was_busy);
		r = apply_list_request(k, p, v);
		pending_replies.push_back(r);
		request_count++;
		kind_count[k]++;
		status_count[r.st]++;
		if (shadow_len > deepest_list)
			deepest_list = shadow_len;
		if (int'(r.found) > deepest_match)
			deepest_match = r.found;
	endtask

	task automatic idle_gap();
		while ($urandom_range(99) < idle_pct) begin
			start    <= 1'b0;
			kind     <= 2'($urandom);
			position <= 8'($urandom);
			value    <= $urandom;
			@(posedge clk);
		end
	endtask

	task automatic wait_for_replies();
		start <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk) begin
		list_reply_t exp_r;
		if (arst_n === 1'b1 && done !== 1'b0) begin
			if (pending_replies.size() == 0) begin
				$error("unexpected result: status=%0d found_position=%0d entry_count=%0d",
					status, found_position, entry_count);
				error_count++;
			end else begin
				exp_r = pending_replies.pop_front();
				if (status !== exp_r.st) begin
					$error("status: expected %0d, actual %0d", exp_r.st, status);
					error_count++;
				end
				if (found_position !== exp_r.found) begin
					$error("found_position: expected %0d, actual %0d",
						exp_r.found, found_position);
					error_count++;
				end
				if (entry_count !== exp_r.cnt) begin
					$error("entry_count: expected %0d, actual %0d", exp_r.cnt, entry_count);
					error_count++;
				end
			end
		end
	end

	function automatic bit [31:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return $urandom;
		if (r < 75)
			return 32'(int'($urandom_range(16)) - 8);
		if (r < 85) begin
			case ($urandom_range(3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0000_0000;
				default: return 32'hffff_ffff;
			endcase
		end
		if (shadow_len > 0)
			return shadow_mem[$urandom_range(shadow_len - 1)];
		return $urandom;
	endfunction

	task automatic send_random_request(walk_mode_t mode);
		int        r;
		int        ins_w;
		int        del_w;
		kind_t     k;
		bit [7:0]  p;
		bit [31:0] v;
		case (mode)
			MODE_GROW: begin
				ins_w = 60;
				del_w = 15;
			end
			MODE_SHRINK: begin
				ins_w = 20;
				del_w = 50;
			end
			default: begin
				ins_w = 38;
				del_w = 32;
			end
		endcase
		r = $urandom_range(99);
		if (r < ins_w)
			k = KIND_INSERT;
		else if (r < ins_w + del_w)
			k = KIND_DELETE;
		else if (r < 98)
			k = KIND_LOCATE;
		else
			k = KIND_CLEAR;
		p = 8'($urandom);
		v = $urandom;
		case (k)
			KIND_INSERT: begin
				if ($urandom_range(99) < 85)
					p = 8'($urandom_range(shadow_len + 1, 1));
				v = pick_value();
			end
			KIND_DELETE: begin
				if (shadow_len > 0 && $urandom_range(99) < 85)
					p = 8'($urandom_range(shadow_len, 1));
			end
			KIND_LOCATE: begin
				if (shadow_len > 0 && $urandom_range(99) < 60)
					v = shadow_mem[$urandom_range(shadow_len - 1)];
				else
					v = pick_value();
			end
			default: ;
		endcase
		send_request(k, p, v);
	endtask

	task automatic test_directed();
		idle_pct = 0;
		send_request(KIND_DELETE, 8'd1, 32'h1111_1111);
		send_request(KIND_LOCATE, 8'd0, 32'h0000_0000);
		send_request(KIND_INSERT, 8'd0, 32'h0000_0005);
		send_request(KIND_INSERT, 8'd2, 32'h0000_0005);
		send_request(KIND_INSERT, 8'd1, 32'h8000_0000);
		send_request(KIND_INSERT, 8'd2, 32'h7fff_ffff);
		send_request(KIND_INSERT, 8'd1, 32'hffff_ffff);
		send_request(KIND_INSERT, 8'd4, 32'h0000_0000);
		send_request(KIND_INSERT, 8'd255, 32'h0000_0009);
		send_request(KIND_INSERT, 8'd2, 32'h7fff_ffff);
		send_request(KIND_LOCATE, 8'd0, 32'h7fff_ffff);
		send_request(KIND_LOCATE, 8'd3, 32'h7fff_fffe);
		send_request(KIND_LOCATE, 8'd255, 32'h8000_0000);
		send_request(KIND_DELETE, 8'd0, 32'h0000_0000);
		send_request(KIND_DELETE, 8'd6, 32'hffff_ffff);
		send_request(KIND_DELETE, 8'd5, 32'h7fff_ffff);
		send_request(KIND_DELETE, 8'd1, 32'hffff_ffff);
		send_request(KIND_LOCATE, 8'd128, 32'h0000_0000);
		send_request(KIND_CLEAR, 8'd77, 32'h1234_5678);
		send_request(KIND_LOCATE, 8'd1, 32'h0000_0000);
		send_request(KIND_DELETE, 8'd1, 32'h0000_0000);
		send_request(KIND_INSERT, 8'd1, 32'h0000_0000);
		send_request(KIND_LOCATE, 8'd0, 32'h0000_0000);
		wait_for_replies();
	endtask

	task automatic test_capacity();
		int i;
		idle_pct = 8;
		send_request(KIND_CLEAR, 8'($urandom), $urandom);
		idle_gap();
		for (i = 0; i < LIST_DEPTH - 1; i++) begin
			send_request(KIND_INSERT, 8'($urandom_range(shadow_len + 1, 1)), pick_value());
			idle_gap();
		end
		send_request(KIND_INSERT, 8'(shadow_len + 1), 32'h5a5a_c3c3);
		idle_gap();
		send_request(KIND_INSERT, 8'd1, $urandom);
		idle_gap();
		send_request(KIND_INSERT, 8'd0, $urandom);
		idle_gap();
		send_request(KIND_INSERT, 8'd200, $urandom);
		idle_gap();
		send_request(KIND_LOCATE, 8'($urandom), 32'h5a5a_c3c3);
		idle_gap();
		send_request(KIND_LOCATE, 8'($urandom), shadow_mem[LIST_DEPTH - 1]);
		idle_gap();
		send_request(KIND_LOCATE, 8'($urandom), $urandom);
		idle_gap();
		send_request(KIND_DELETE, 8'd129, $urandom);
		idle_gap();
		send_request(KIND_DELETE, 8'd128, $urandom);
		idle_gap();
		send_request(KIND_DELETE, 8'd128, $urandom);
		idle_gap();
		send_request(KIND_INSERT, 8'd128, 32'h8000_0000);
		idle_gap();
		send_request(KIND_LOCATE, 8'd0, 32'h8000_0000);
		wait_for_replies();
	endtask

	task automatic test_random(int n_items, int phase_idle);
		int         i;
		walk_mode_t mode;
		mode = MODE_MIXED;
		for (i = 0; i < n_items; i++) begin
			if (i % SEGMENT_LEN == 0) begin
				mode     = walk_mode_t'($urandom_range(2));
				idle_pct = ($urandom_range(3) == 0) ? 0 : phase_idle;
			end
			send_random_request(mode);
			idle_gap();
			if (i == n_items / 2)
				wait_for_replies();
		end
	endtask

	initial begin
		arst_n   <= 1'b0;
		start    <= 1'b0;
		kind     <= KIND_INSERT;
		position <= '0;
		value    <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_capacity();
		test_random(560, 0);
		test_random(560, 71);
		test_random(560, 8);

		wait_for_replies();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d insert, %0d delete, %0d locate, %0d clear.",
			request_count, kind_count[KIND_INSERT], kind_count[KIND_DELETE],
			kind_count[KIND_LOCATE], kind_count[KIND_CLEAR]);
		$display("Outcomes ok/full/range/not-found %0d/%0d/%0d/%0d; list depth %0d, match at %0d.",
			status_count[ST_OK], status_count[ST_FULL], status_count[ST_RANGE],
			status_count[ST_NOTFOUND], deepest_list, deepest_match);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire
